/* hw/rtl/srmv_pkg.sv */
// Package for the serial receive majority-vote core.
// Holds the configuration and result types, register indexes and reset values.
// No dependencies.
`default_nettype none

package srmv_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIMEOUT_LIMIT    = 3'd0,
    REG_FRAME_LENGTH     = 3'd1,
    REG_FIRST_BIT_SAMPLE = 3'd2,
    REG_SAMPLES_PER_BIT  = 3'd3,
    REG_VOTE_THRESHOLD   = 3'd4
  } reg_index_t;

  localparam logic [15:0] TIMEOUT_LIMIT_RST    = 16'd10000;
  localparam logic [7:0]  FRAME_LENGTH_RST     = 8'd117;
  localparam logic [6:0]  FIRST_BIT_SAMPLE_RST = 7'd12;
  localparam logic [3:0]  SAMPLES_PER_BIT_RST  = 4'd10;
  localparam logic [3:0]  VOTE_THRESHOLD_RST   = 4'd4;

  typedef struct packed {
    logic [15:0] timeout_limit;
    logic [7:0]  frame_length;
    logic [6:0]  first_bit_sample;
    logic [3:0]  samples_per_bit;
    logic [3:0]  vote_threshold;
  } cfg_t;

  typedef struct packed {
    logic       timed_out;
    logic [7:0] byte_value;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/serial_rx_majority_vote_core.sv */
// Serial receive core with majority-vote bit recovery over oversampled line ticks.
// One line sample per request on the input stream; one result request per byte or timeout.
// The input stream carries one sample per request; s_axis_tdata[0] is the line level.
// The output stream carries the received byte on m_axis_tdata and the timeout flag
// on m_axis_tuser; a timeout result has data zero.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must write it only while idle, as the block does not enforce this. cfg_ready is
// always high and indexes past the register list are ignored.
// Throughput: one sample per cycle while s_axis_tready is high.
// The output register is backed by a one-entry skid buffer, so samples keep flowing
// while a result waits; s_axis_tready drops only when both entries are full.
// Reset (rst, synchronous) loads the default configuration, returns the sampler to
// idle with cleared counters and empties both output entries.
`default_nettype none

module serial_rx_majority_vote_core
  import srmv_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [0] line_level, [7:1] zero
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [7:0] byte_value
  output logic                        m_axis_tuser,   // [0] timed_out
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  logic    step;
  logic    res_valid;
  result_t res;
  logic    out_valid, skid_valid;
  result_t out_res, skid_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_limit    <= TIMEOUT_LIMIT_RST;
      cfg.frame_length     <= FRAME_LENGTH_RST;
      cfg.first_bit_sample <= FIRST_BIT_SAMPLE_RST;
      cfg.samples_per_bit  <= SAMPLES_PER_BIT_RST;
      cfg.vote_threshold   <= VOTE_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIMEOUT_LIMIT:    cfg.timeout_limit    <= cfg_data;
        REG_FRAME_LENGTH:     cfg.frame_length     <= cfg_data[7:0];
        REG_FIRST_BIT_SAMPLE: cfg.first_bit_sample <= cfg_data[6:0];
        REG_SAMPLES_PER_BIT:  cfg.samples_per_bit  <= cfg_data[3:0];
        REG_VOTE_THRESHOLD:   cfg.vote_threshold   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_valid;
  assign step          = s_axis_tvalid && s_axis_tready;

  srmv_sampler #(
    .DATA_BITS (DATA_BITS)
  ) u_sampler (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (step),
    .line_level (s_axis_tdata[0]),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register with a skid entry behind it; the skid entry is always drained first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_axis_tready) begin
      if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= res_valid;
    end else begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_axis_tready) begin
      if (res_valid) begin
        skid_res <= res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
      if (res_valid) begin
        skid_res <= res;
      end
    end else if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.byte_value;
  assign m_axis_tuser  = out_res.timed_out;

  skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_axis_tready) |=> (out_valid && out_res == $past(skid_res)))
    else $error("skid entry was not moved to the output register");

  stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (out_valid && skid_valid))
    else $error("input stalled with a free output entry");

  reset_empties_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

/* hw/rtl/srmv_sampler.sv */
// Line sampler: idle timeout counter, frame sample counter and voting windows.
// Updates its state once per accepted sample and flags a result in the same cycle.
// Depends on srmv_pkg.
`default_nettype none

module srmv_sampler
  import srmv_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    step,
  input  wire logic    line_level,
  output logic         res_valid,
  output result_t      res
);

  localparam int BW = $clog2(DATA_BITS + 1);

  logic                 receiving, receiving_next;
  logic [15:0]          idle_ticks, idle_ticks_next;
  logic [7:0]           sample_index, sample_index_next;
  logic [BW-1:0]        win_bit, win_bit_next;
  logic [3:0]           win_pos, win_pos_next;
  logic [3:0]           vote_counts [DATA_BITS];
  logic [3:0]           vote_counts_next [DATA_BITS];

  logic [15:0] limit_eff;
  logic [7:0]  len_eff;
  logic [3:0]  spb_eff;
  logic [15:0] idle_inc;
  logic        in_window;
  logic        bits_left;
  logic        last_sample;
  logic [7:0]  value;

  assign limit_eff   = (cfg.timeout_limit == '0) ? 16'd1 : cfg.timeout_limit;
  assign len_eff     = (cfg.frame_length == '0) ? 8'd1 : cfg.frame_length;
  assign spb_eff     = (cfg.samples_per_bit == '0) ? 4'd1 : cfg.samples_per_bit;
  assign idle_inc    = idle_ticks + 16'd1;
  assign in_window   = sample_index >= {1'b0, cfg.first_bit_sample};
  assign bits_left   = win_bit < BW'(DATA_BITS);
  assign last_sample = ({1'b0, sample_index} + 9'd1) >= {1'b0, len_eff};

  always_comb begin
    receiving_next    = receiving;
    idle_ticks_next   = idle_ticks;
    sample_index_next = sample_index;
    win_bit_next      = win_bit;
    win_pos_next      = win_pos;
    vote_counts_next  = vote_counts;
    res_valid         = 1'b0;
    res               = '0;
    value             = '0;

    if (!receiving) begin
      if (!line_level) begin
        receiving_next    = 1'b1;
        sample_index_next = '0;
        idle_ticks_next   = '0;
        win_bit_next      = '0;
        win_pos_next      = '0;
      end else if (idle_inc >= limit_eff) begin
        idle_ticks_next = '0;
        res_valid       = 1'b1;
        res.timed_out   = 1'b1;
      end else begin
        idle_ticks_next = idle_inc;
      end
    end else begin
      // The window position walks with the sample index once the first window opens.
      if (in_window && bits_left) begin
        for (int b = 0; b < DATA_BITS; b++) begin
          if (line_level && win_bit == BW'(b) && vote_counts[b] != 4'd15) begin
            vote_counts_next[b] = vote_counts[b] + 4'd1;
          end
        end
        if (win_pos == spb_eff - 4'd1) begin
          win_pos_next = '0;
          win_bit_next = win_bit + BW'(1);
        end else begin
          win_pos_next = win_pos + 4'd1;
        end
      end

      if (last_sample) begin
        for (int b = 0; b < DATA_BITS; b++) begin
          if (b < 8 && vote_counts_next[b] > cfg.vote_threshold) begin
            value[b] = 1'b1;
          end
        end
        for (int b = 0; b < DATA_BITS; b++) begin
          vote_counts_next[b] = '0;
        end
        receiving_next    = 1'b0;
        sample_index_next = '0;
        idle_ticks_next   = '0;
        res_valid         = 1'b1;
        res.byte_value    = value;
      end else begin
        sample_index_next = sample_index + 8'd1;
      end
    end

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving    <= 1'b0;
      idle_ticks   <= '0;
      sample_index <= '0;
      win_bit      <= '0;
      win_pos      <= '0;
      for (int b = 0; b < DATA_BITS; b++) begin
        vote_counts[b] <= '0;
      end
    end else if (step) begin
      receiving    <= receiving_next;
      idle_ticks   <= idle_ticks_next;
      sample_index <= sample_index_next;
      win_bit      <= win_bit_next;
      win_pos      <= win_pos_next;
      vote_counts  <= vote_counts_next;
    end
  end

  window_in_range: assert property (@(posedge clk) disable iff (rst)
    win_bit <= BW'(DATA_BITS))
    else $error("voting window index ran past the data bits");

  idle_counter_quiet: assert property (@(posedge clk) disable iff (rst)
    receiving |-> idle_ticks == '0)
    else $error("idle counter moved during a frame");

  no_timeout_in_frame: assert property (@(posedge clk) disable iff (rst)
    (res_valid && receiving) |-> !res.timed_out)
    else $error("timeout result raised inside a frame");

endmodule

`default_nettype wire
